// ===== rtl/core/ppce_pkg.sv =====
// Package for the pixel plot command engine.
// Holds the word types, the function and command codes and the palette
// lookup. Depends on nothing.
package ppce_pkg;

  localparam int unsigned COORD_BITS = 8;
  localparam int unsigned ADDR_BITS  = 2 * COORD_BITS;
  localparam int unsigned PIX_BITS   = 4;
  localparam int unsigned RGB_BITS   = 24;
  localparam int unsigned CMD_BITS   = 3;

  typedef enum logic [1:0] {
    FUNC_DATA = 2'd0,
    FUNC_CMD  = 2'd1,
    FUNC_TRIG = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  localparam logic [CMD_BITS-1:0] CMD_PLOT   = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_X = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_Y = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd3;

  localparam logic REG_CMD_POS = 1'b0;
  localparam logic REG_PALETTE = 1'b1;

  // Data latch bits that steer plot stepping.
  localparam int unsigned STEP_X_BIT = 4;
  localparam int unsigned STEP_Y_BIT = 5;
  localparam int unsigned DEC_X_BIT  = 6;
  localparam int unsigned DEC_Y_BIT  = 7;

  typedef struct packed {
    func_t                 func;
    logic [7:0]            byte_value;
    logic                  line_level;
    logic [COORD_BITS-1:0] read_x;
    logic [COORD_BITS-1:0] read_y;
  } in_word_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]   pixel_index;
    logic [RGB_BITS-1:0]   pixel_rgb;
    logic                  clear_done;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
  } out_word_t;

  // Bit 0 drives red, bit 1 green, bit 2 blue. In RGBI mode bit 3 lifts
  // every unlit channel to a dim background level.
  function automatic logic [RGB_BITS-1:0] colour_of(input logic [PIX_BITS-1:0] idx,
                                                    input logic               rgbi);
    logic [7:0] bg;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bg = (rgbi && idx[3]) ? 8'h40 : 8'h00;
    r  = idx[0] ? 8'hff : bg;
    g  = idx[1] ? 8'hff : bg;
    b  = idx[2] ? 8'hff : bg;
    return {r, g, b};
  endfunction

endpackage

// ===== rtl/core/pixel_plot_command_engine_top.sv =====
// Top level of the pixel plot command engine.
// Holds the frame store memory, the cursor and command registers and the
// fill sequencer. Depends on ppce_pkg.

// The engine takes one command word at a time: a word is accepted on a rising
// edge with start high and busy low, and exactly one result word follows on
// out_data, marked by out_valid for a single cycle; the receiver cannot stall
// it. Data writes, command writes and triggers other than a clear answer in the
// next cycle and leave busy low, so a new word may follow at once. A pixel read
// passes through a wait state because the frame store is a synchronous memory
// with a registered read port: the read is issued on acceptance and the palette
// is applied to the data in the cycle after. A clear command walks the
// 65536-entry store one pixel per cycle, so busy stays high for the whole sweep
// and the result, with clear_done set, appears in the cycle after the last pixel
// is written. After reset the same sequencer runs a clearing pass that writes
// zero to every pixel; busy is high throughout and no result is produced.
// Configuration writes are taken in any cycle and should only be made while
// the engine is idle.
module pixel_plot_command_engine_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ppce_pkg::in_word_t   in_data,
  output logic                 out_valid,
  output ppce_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_t;

  state_t state_r;

  logic [ppce_pkg::COORD_BITS-1:0] cur_x_r;
  logic [ppce_pkg::COORD_BITS-1:0] cur_y_r;
  logic [ppce_pkg::CMD_BITS-1:0]   cmd_r;
  logic [7:0]                      latch_r;
  logic                            cmd_pos_r;
  logic                            pal_mode_r;

  logic [ppce_pkg::ADDR_BITS-1:0]  fill_cnt_r;
  logic [ppce_pkg::PIX_BITS-1:0]   fill_val_r;
  logic                            fill_report_r;

  logic                            out_valid_r;
  ppce_pkg::out_word_t             out_data_r;

  // Frame store: one write port, one registered read port.
  logic [ppce_pkg::PIX_BITS-1:0]   frame_mem [2**ppce_pkg::ADDR_BITS];
  logic [ppce_pkg::PIX_BITS-1:0]   rd_data_r;
  logic [ppce_pkg::ADDR_BITS-1:0]  rd_addr;
  logic                            wr_en;
  logic [ppce_pkg::ADDR_BITS-1:0]  wr_addr;
  logic [ppce_pkg::PIX_BITS-1:0]   wr_val;

  logic                            accept;
  logic                            trig_run;
  logic                            clear_start;
  logic [ppce_pkg::COORD_BITS-1:0] step_x;
  logic [ppce_pkg::COORD_BITS-1:0] step_y;
  logic [ppce_pkg::COORD_BITS-1:0] cur_x_nxt;
  logic [ppce_pkg::COORD_BITS-1:0] cur_y_nxt;
  logic [ppce_pkg::PIX_BITS-1:0]   rd_idx;
  logic                            fill_last;

  assign busy        = (state_r != ST_IDLE);
  assign accept      = start && !busy;
  assign trig_run    = accept && (in_data.func == ppce_pkg::FUNC_TRIG) && !in_data.line_level;
  assign clear_start = trig_run && (cmd_r == ppce_pkg::CMD_CLEAR);
  assign fill_last   = (fill_cnt_r == {ppce_pkg::ADDR_BITS{1'b1}});

  // Plot stepping happens before the pixel is written.
  always_comb begin
    step_x = cur_x_r;
    step_y = cur_y_r;
    if (latch_r[ppce_pkg::STEP_X_BIT]) begin
      step_x = latch_r[ppce_pkg::DEC_X_BIT] ? cur_x_r - 8'd1 : cur_x_r + 8'd1;
    end
    if (latch_r[ppce_pkg::STEP_Y_BIT]) begin
      step_y = latch_r[ppce_pkg::DEC_Y_BIT] ? cur_y_r - 8'd1 : cur_y_r + 8'd1;
    end
  end

  // Cursor values after a trigger; unused commands leave them alone.
  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (trig_run) begin
      unique case (cmd_r)
        ppce_pkg::CMD_PLOT: begin
          cur_x_nxt = step_x;
          cur_y_nxt = step_y;
        end
        ppce_pkg::CMD_LOAD_X: cur_x_nxt = latch_r;
        ppce_pkg::CMD_LOAD_Y: cur_y_nxt = latch_r;
        default: ;
      endcase
    end
  end

  // The store is addressed row-major: the row forms the upper byte.
  assign rd_addr = {in_data.read_y, in_data.read_x};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {step_y, step_x};
    wr_val  = latch_r[ppce_pkg::PIX_BITS-1:0];
    if (state_r == ST_FILL) begin
      wr_en   = 1'b1;
      wr_addr = fill_cnt_r;
      wr_val  = fill_val_r;
    end else if (trig_run && (cmd_r == ppce_pkg::CMD_PLOT)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_val;
    end
    rd_data_r <= frame_mem[rd_addr];
  end

  // In RGB mode only the low three index bits count.
  assign rd_idx = pal_mode_r ? rd_data_r : {1'b0, rd_data_r[2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_pos_r  <= 1'b0;
      pal_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppce_pkg::REG_CMD_POS: cmd_pos_r  <= cfg_data;
        ppce_pkg::REG_PALETTE: pal_mode_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_FILL;
      fill_cnt_r    <= '0;
      fill_val_r    <= '0;
      fill_report_r <= 1'b0;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      cmd_r         <= '0;
      latch_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          // A pixel read and a clear answer later, from their own states.
          out_valid_r <= accept && (in_data.func != ppce_pkg::FUNC_READ) && !clear_start;
          if (accept) begin
            out_data_r.pixel_index <= '0;
            out_data_r.pixel_rgb   <= '0;
            out_data_r.clear_done  <= 1'b0;
            out_data_r.cursor_x    <= cur_x_nxt;
            out_data_r.cursor_y    <= cur_y_nxt;
            cur_x_r                <= cur_x_nxt;
            cur_y_r                <= cur_y_nxt;
            unique case (in_data.func)
              ppce_pkg::FUNC_DATA: begin
                latch_r <= in_data.byte_value;
              end
              ppce_pkg::FUNC_CMD: begin
                cmd_r <= cmd_pos_r ? in_data.byte_value[5:3] : in_data.byte_value[2:0];
              end
              ppce_pkg::FUNC_TRIG: begin
                if (clear_start) begin
                  // The result waits for the end of the sweep.
                  fill_cnt_r    <= '0;
                  fill_val_r    <= latch_r[ppce_pkg::PIX_BITS-1:0];
                  fill_report_r <= 1'b1;
                  state_r       <= ST_FILL;
                end
              end
              ppce_pkg::FUNC_READ: begin
                state_r <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          out_data_r.pixel_index <= rd_idx;
          out_data_r.pixel_rgb   <= ppce_pkg::colour_of(rd_idx, pal_mode_r);
          out_valid_r            <= 1'b1;
          state_r                <= ST_IDLE;
        end
        ST_FILL: begin
          fill_cnt_r  <= fill_cnt_r + {{(ppce_pkg::ADDR_BITS-1){1'b0}}, 1'b1};
          out_valid_r <= fill_last && fill_report_r;
          if (fill_last) begin
            state_r       <= ST_IDLE;
            fill_report_r <= 1'b0;
            if (fill_report_r) begin
              out_data_r.pixel_index <= '0;
              out_data_r.pixel_rgb   <= '0;
              out_data_r.clear_done  <= 1'b1;
              out_data_r.cursor_x    <= cur_x_r;
              out_data_r.cursor_y    <= cur_y_r;
            end
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The clearing pass starts right after reset.
  a_reset_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> busy) else $error("no clearing pass after reset");

  // An accepted pixel read keeps the engine busy, with no result, in the next cycle.
  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.func == ppce_pkg::FUNC_READ) |=> (busy && !out_valid))
    else $error("pixel read did not wait for memory data");

  // The read wait state always ends in a result.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (out_valid && !busy))
    else $error("pixel read produced no result");

  // A clear result carries no colour.
  a_clear_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clear_done) |-> (out_data.pixel_rgb == '0 &&
                                             out_data.pixel_index == '0))
    else $error("clear result carries pixel data");

  // In RGB mode the index never uses its top bit.
  a_rgb_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !pal_mode_r) |-> !out_data.pixel_index[3])
    else $error("RGB mode index not masked");

endmodule
